@@ sv/tpi_pkg.sv @@
// ----------------------------------------------------------------------------
// tpi_pkg
// Shared types and saturating fixed-point helpers for the trapezoid
// power integrator (Q40.24 words, 128-bit magnitude products).
// ----------------------------------------------------------------------------
package tpi_pkg;

   localparam int WORD_W    = 64;
   localparam int PROD_W    = 128;
   localparam int FRAC_BITS = 24;

   // value plus saturation flag
   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic              ov;
   } sat_type;

   localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
   localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};

   // two's complement magnitude; the most negative word maps to 2^63
   function automatic logic [WORD_W-1:0] magnitude(input logic [WORD_W-1:0] v);
      magnitude = v[WORD_W-1] ? (~v + WORD_W'(1)) : v;
   endfunction

   // saturating signed add
   function automatic sat_type sat_add(input logic [WORD_W-1:0] p,
                                       input logic [WORD_W-1:0] q);
      logic [WORD_W-1:0] s;
      sat_type           r;
      s = p + q;
      r.ov    = 1'b0;
      r.value = s;
      if ((p[WORD_W-1] == q[WORD_W-1]) && (s[WORD_W-1] != p[WORD_W-1])) begin
         r.ov    = 1'b1;
         r.value = p[WORD_W-1] ? WORD_MIN : WORD_MAX;
      end
      return r;
   endfunction

   // scale an exact magnitude product back to Q40.24 (truncate toward zero),
   // apply the sign and saturate
   function automatic sat_type prod_sat(input logic [PROD_W-1:0] prod,
                                        input logic              neg);
      logic              big;
      logic [WORD_W-1:0] mag;
      sat_type           r;
      big = |prod[PROD_W-1:WORD_W+FRAC_BITS];
      mag = prod[WORD_W+FRAC_BITS-1:FRAC_BITS];
      r.ov = 1'b0;
      if (neg) begin
         if (big || (mag[WORD_W-1] && (|mag[WORD_W-2:0]))) begin
            r.ov    = 1'b1;
            r.value = WORD_MIN;
         end else begin
            r.value = ~mag + WORD_W'(1);
         end
      end else begin
         if (big || mag[WORD_W-1]) begin
            r.ov    = 1'b1;
            r.value = WORD_MAX;
         end else begin
            r.value = mag;
         end
      end
      return r;
   endfunction

endpackage

@@ sv/trapezoid_power_integrator.sv @@
// ----------------------------------------------------------------------------
// trapezoid_power_integrator
// Trapezoidal-rule estimate of the integral of x^p over [a, b], Q8.24 in,
// saturated Q40.24 out, on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
// Sequence: n and p are clamped first (p=0 counts as 1). Each 64x64 product
//   runs setup, four partials and scale on the single 32x32 multiplier.
// Throughput: one item at a time; busy stays high until the result beat.
// Reset: synchronous, active high; returns to idle and drops busy/rsp_valid.
// Result is a one-cycle rsp_valid strobe; the receiver cannot stall it.
module trapezoid_power_integrator #(
   parameter int MAX_STEPS = 1048576,
   parameter int MAX_POWER = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_lower_bound,
   input  logic signed [31:0] req_upper_bound,
   input  logic        [20:0] req_step_count,
   input  logic signed [31:0] req_step_width,
   input  logic        [2:0]  req_power,
   output logic               rsp_valid,
   output logic signed [63:0] rsp_area,
   output logic               rsp_overflowed
);

   localparam int CNT_W = $clog2(MAX_STEPS + 1);
   localparam int EXP_W = $clog2(MAX_POWER + 1);
   localparam int W     = tpi_pkg::WORD_W;
   localparam int PW    = tpi_pkg::PROD_W;

   typedef enum logic [3:0] {
      S_IDLE,       // waiting for start
      S_POW_START,  // load base into the power register
      S_POW_STEP,   // one more multiply needed, or the power is done
      S_MUL,        // four 32x32 partial products into the 128-bit sum
      S_SAT,        // scale/saturate the product, route it
      S_ACC,        // keep a^p, or fold a finished power into the running sum
      S_HALF,       // halve the end sum toward zero
      S_NEXT        // step to the next interior point or the final product
   } state_type;

   typedef enum logic [1:0] {
      PH_LO,        // evaluating a^p
      PH_HI,        // evaluating b^p
      PH_PT,        // evaluating an interior point
      PH_FIN        // sum times width
   } phase_type;

   state_type           state_ff, state_in;
   phase_type           phase_ff, phase_in;
   logic [W-1:0]        base_ff, base_in;     // value being raised
   logic [W-1:0]        pw_ff, pw_in;         // running power
   logic [W-1:0]        lop_ff, lop_in;       // a^p, kept while b^p runs
   logic [W-1:0]        hi_ff, hi_in;         // upper end, sign-extended
   logic [W-1:0]        acc_ff, acc_in;       // running sum
   logic [W-1:0]        pt_ff, pt_in;         // current interior point
   logic [W-1:0]        width_ff, width_in;   // step width, sign-extended
   logic [EXP_W-1:0]    expo_ff, expo_in;     // multiplies per power (p-1)
   logic [EXP_W-1:0]    pcnt_ff, pcnt_in;     // multiplies left
   logic [CNT_W-1:0]    steps_ff, steps_in;
   logic [CNT_W-1:0]    kcnt_ff, kcnt_in;     // interior point index
   logic [W-1:0]        ma_ff, ma_in;         // multiplier operand magnitudes
   logic [W-1:0]        mb_ff, mb_in;
   logic                mneg_ff, mneg_in;
   logic [PW-1:0]       prod_ff, prod_in;
   logic [1:0]          mc_ff, mc_in;         // partial product select
   logic                ovf_ff, ovf_in;       // sticky saturation flag
   logic [W-1:0]        area_ff, area_in;
   logic                valid_ff, valid_in;

   // shared multiplier datapath
   logic [31:0]         mul_a, mul_b;
   logic [W-1:0]        mul_pp;
   logic [PW-1:0]       mul_pp_sh;
   tpi_pkg::sat_type    mul_res;
   tpi_pkg::sat_type    add_res;
   logic [W-1:0]        half_sum;
   logic [W-1:0]        pt_next;
   logic [2:0]          pow_eff;

   assign mul_a  = mc_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
   assign mul_b  = mc_ff[0] ? mb_ff[63:32] : mb_ff[31:0];
   assign mul_pp = W'(mul_a) * W'(mul_b);

   always_comb begin
      case (mc_ff)
         2'd0:    mul_pp_sh = {64'd0, mul_pp};
         2'd3:    mul_pp_sh = {mul_pp, 64'd0};
         default: mul_pp_sh = {32'd0, mul_pp, 32'd0};
      endcase
   end

   assign mul_res  = tpi_pkg::prod_sat(prod_ff, mneg_ff);
   // add operands depend on phase: end sum or running sum
   assign add_res  = (phase_ff == PH_HI) ? tpi_pkg::sat_add(lop_ff, pw_ff)
                                         : tpi_pkg::sat_add(acc_ff, pw_ff);
   assign half_sum = acc_ff + W'(acc_ff[W-1]);
   // interior points never leave 64 bits: |a| <= 2^31, n*|w| <= 2^51
   assign pt_next  = pt_ff + width_ff;
   // power 0 behaves as 1
   assign pow_eff  = (req_power == 3'd0) ? 3'd1 : req_power;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      base_in  = base_ff;
      pw_in    = pw_ff;
      lop_in   = lop_ff;
      hi_in    = hi_ff;
      acc_in   = acc_ff;
      pt_in    = pt_ff;
      width_in = width_ff;
      expo_in  = expo_ff;
      pcnt_in  = pcnt_ff;
      steps_in = steps_ff;
      kcnt_in  = kcnt_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      mneg_in  = mneg_ff;
      prod_in  = prod_ff;
      mc_in    = mc_ff;
      ovf_in   = ovf_ff;
      area_in  = area_ff;
      valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               base_in  = W'(req_lower_bound);
               pt_in    = W'(req_lower_bound);
               hi_in    = W'(req_upper_bound);
               width_in = W'(req_step_width);
               // clamp exponent and step count to the build limits
               if (32'(pow_eff) > MAX_POWER) begin
                  expo_in = EXP_W'(MAX_POWER - 1);
               end else begin
                  expo_in = EXP_W'(pow_eff - 3'd1);
               end
               if (32'(req_step_count) > MAX_STEPS) begin
                  steps_in = CNT_W'(MAX_STEPS);
               end else begin
                  steps_in = CNT_W'(req_step_count);
               end
               ovf_in   = 1'b0;
               phase_in = PH_LO;
               state_in = S_POW_START;
            end
         end
         S_POW_START: begin
            pw_in    = base_ff;
            pcnt_in  = expo_ff;
            state_in = S_POW_STEP;
         end
         S_POW_STEP: begin
            if (pcnt_ff == '0) begin
               state_in = S_ACC;
            end else begin
               ma_in    = tpi_pkg::magnitude(pw_ff);
               mb_in    = tpi_pkg::magnitude(base_ff);
               mneg_in  = pw_ff[W-1] ^ base_ff[W-1];
               prod_in  = '0;
               mc_in    = 2'd0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in = prod_ff + mul_pp_sh;
            mc_in   = mc_ff + 2'd1;
            if (mc_ff == 2'd3) begin
               state_in = S_SAT;
            end
         end
         S_SAT: begin
            ovf_in = ovf_ff | mul_res.ov;
            if (phase_ff == PH_FIN) begin
               area_in  = mul_res.value;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               // saturated value keeps feeding the next multiply
               pw_in    = mul_res.value;
               pcnt_in  = pcnt_ff - EXP_W'(1);
               state_in = S_POW_STEP;
            end
         end
         S_ACC: begin
            case (phase_ff)
               PH_LO: begin
                  lop_in   = pw_ff;
                  base_in  = hi_ff;
                  phase_in = PH_HI;
                  state_in = S_POW_START;
               end
               PH_HI: begin
                  acc_in   = add_res.value;
                  ovf_in   = ovf_ff | add_res.ov;
                  state_in = S_HALF;
               end
               default: begin
                  acc_in   = add_res.value;
                  ovf_in   = ovf_ff | add_res.ov;
                  state_in = S_NEXT;
               end
            endcase
         end
         S_HALF: begin
            // divide by two, rounding toward zero
            acc_in   = {half_sum[W-1], half_sum[W-1:1]};
            kcnt_in  = CNT_W'(1);
            state_in = S_NEXT;
         end
         S_NEXT: begin
            if (kcnt_ff >= steps_ff) begin
               ma_in    = tpi_pkg::magnitude(acc_ff);
               mb_in    = tpi_pkg::magnitude(width_ff);
               mneg_in  = acc_ff[W-1] ^ width_ff[W-1];
               prod_in  = '0;
               mc_in    = 2'd0;
               phase_in = PH_FIN;
               state_in = S_MUL;
            end else begin
               pt_in    = pt_next;
               base_in  = pt_next;
               kcnt_in  = kcnt_ff + CNT_W'(1);
               phase_in = PH_PT;
               state_in = S_POW_START;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_LO;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
      base_ff  <= base_in;
      pw_ff    <= pw_in;
      lop_ff   <= lop_in;
      hi_ff    <= hi_in;
      acc_ff   <= acc_in;
      pt_ff    <= pt_in;
      width_ff <= width_in;
      expo_ff  <= expo_in;
      pcnt_ff  <= pcnt_in;
      steps_ff <= steps_in;
      kcnt_ff  <= kcnt_in;
      ma_ff    <= ma_in;
      mb_ff    <= mb_in;
      mneg_ff  <= mneg_in;
      prod_ff  <= prod_in;
      mc_ff    <= mc_in;
      ovf_ff   <= ovf_in;
      area_ff  <= area_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = valid_ff;
   assign rsp_area       = area_ff;
   assign rsp_overflowed = ovf_ff;

endmodule

@@ sv/tpi_checker.sv @@
// ----------------------------------------------------------------------------
// tpi_checker
// Port-level checks on the integrator's start/busy/result beats.
// ----------------------------------------------------------------------------
module tpi_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // accepted beat makes the block busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted beat");

   // result beats are isolated single-cycle strobes
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("rsp_valid held longer than one cycle");

   // a result ends the item: never shown while still busy
   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("rsp_valid while busy");

   // leaving busy always delivers the result beat
   a_done_result: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_valid)
      else $error("busy dropped without a result beat");

endmodule

bind trapezoid_power_integrator tpi_checker u_tpi_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

@@ tb/sv/trapezoid_power_integrator_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trapezoid_power_integrator_test
// Self-checking bench for the trapezoid power integrator: directed corners
// (power clamps, zero and clamped step counts, saturation, rounding) then
// random requests, each predicted in fixed point and checked on rsp_valid.
// ----------------------------------------------------------------------------
module trapezoid_power_integrator_test;

   localparam int MAX_STEPS = 1048576;
   localparam int MAX_POWER = 4;

   // Q8.24 handy values
   localparam logic signed [31:0] ONE  = 32'sh0100_0000;
   localparam logic signed [31:0] QMIN = 32'sh8000_0000;
   localparam logic signed [31:0] QMAX = 32'sh7fff_ffff;

   // Q40.24 saturation rails
   localparam logic signed [63:0] AREA_MIN = 64'sh8000_0000_0000_0000;
   localparam logic signed [63:0] AREA_MAX = 64'sh7fff_ffff_ffff_ffff;

   localparam int SETTLE_CYCLES = 200;   // quiet time after the last beat
   localparam int REPORT_LIMIT  = 10;

   // one request beat plus how the sender paces it
   typedef struct {
      logic signed [31:0] lo;
      logic signed [31:0] hi;
      logic        [20:0] steps;
      logic signed [31:0] width;
      logic        [2:0]  expo;
      int unsigned        gap;      // idle cycles before this beat
      bit                 settle;   // hold until every result is back
   } integral_job_type;

   typedef struct {
      logic signed [63:0] area;
      logic               overflowed;
   } area_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [31:0] req_lower_bound = '0;
   logic signed [31:0] req_upper_bound = '0;
   logic        [20:0] req_step_count  = '0;
   logic signed [31:0] req_step_width  = '0;
   logic        [2:0]  req_power       = '0;
   logic               rsp_valid;
   logic signed [63:0] rsp_area;
   logic               rsp_overflowed;

   integral_job_type job_q[$];    // requests not yet driven
   area_type         area_q[$];   // predicted results, oldest first
   integral_job_type cur_job;     // request currently on the req_ ports
   int               in_flight = 0;
   int               idle_cnt  = 0;
   int               calm_left = 0;
   int               miss_cnt  = 0;

   trapezoid_power_integrator #(
      .MAX_STEPS (MAX_STEPS),
      .MAX_POWER (MAX_POWER)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_lower_bound (req_lower_bound),
      .req_upper_bound (req_upper_bound),
      .req_step_count  (req_step_count),
      .req_step_width  (req_step_width),
      .req_power       (req_power),
      .rsp_valid       (rsp_valid),
      .rsp_area        (rsp_area),
      .rsp_overflowed  (rsp_overflowed)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // --------------------------------------------------------------------------
   // Fixed-point predictor
   // --------------------------------------------------------------------------

   // signed add, pinned to the rails on overflow; ov is sticky
   function automatic logic signed [63:0] add_sat(input logic signed [63:0] x,
                                                  input logic signed [63:0] y,
                                                  inout logic ov);
      logic signed [63:0] s;
      s = x + y;
      if (x[63] == y[63] && s[63] != x[63]) begin
         ov = 1'b1;
         return x[63] ? AREA_MIN : AREA_MAX;
      end
      return s;
   endfunction

   // Q40.24 product: exact magnitude product, truncate toward zero, saturate
   function automatic logic signed [63:0] mul_q(input logic signed [63:0] x,
                                                input logic signed [63:0] y,
                                                inout logic ov);
      logic [63:0]  mx;
      logic [63:0]  my;
      logic [63:0]  mag;
      logic [127:0] prod;
      logic         neg;
      logic         big;
      mx   = x[63] ? 64'd0 - x : x;     // most negative word -> 2^63
      my   = y[63] ? 64'd0 - y : y;
      prod = {64'd0, mx} * {64'd0, my};
      big  = |prod[127:88];
      mag  = prod[87:24];
      neg  = x[63] ^ y[63];
      if (neg) begin
         if (big || mag > 64'h8000_0000_0000_0000) begin
            ov = 1'b1;
            return AREA_MIN;
         end
         return 64'd0 - mag;            // exactly 2^63 lands on the rail, no flag
      end
      if (big || mag[63]) begin
         ov = 1'b1;
         return AREA_MAX;
      end
      return mag;
   endfunction

   // x^p by repeated products; a saturated partial keeps being used
   function automatic logic signed [63:0] pow_q(input logic signed [63:0] x,
                                                input int unsigned p,
                                                inout logic ov);
      logic signed [63:0] acc;
      acc = x;
      for (int unsigned k = 1; k < p; k++)
         acc = mul_q(acc, x, ov);
      return acc;
   endfunction

   function automatic area_type trapezoid_area(input integral_job_type j);
      logic signed [63:0] a;
      logic signed [63:0] b;
      logic signed [63:0] w;
      logic signed [63:0] pt;
      logic signed [63:0] acc;
      logic signed [63:0] pa;
      logic signed [63:0] pb;
      logic signed [63:0] pp;
      int unsigned        n;
      int unsigned        p;
      logic               ov;
      area_type           r;
      a  = j.lo;
      b  = j.hi;
      w  = j.width;
      // power 0 acts as 1, anything above the limit clamps
      p  = (j.expo == 0) ? 1 : ((j.expo > MAX_POWER) ? MAX_POWER : j.expo);
      n  = (j.steps > MAX_STEPS) ? MAX_STEPS : j.steps;
      ov = 1'b0;
      pa  = pow_q(a, p, ov);
      pb  = pow_q(b, p, ov);
      acc = add_sat(pa, pb, ov);
      acc = acc / 2;                    // halve toward zero
      // interior points walk from a by w; b is only used at the end
      pt = a;
      for (int unsigned k = 1; k < n; k++) begin
         pt  = pt + w;
         pp  = pow_q(pt, p, ov);
         acc = add_sat(acc, pp, ov);
      end
      r.area       = mul_q(acc, w, ov);
      r.overflowed = ov;
      return r;
   endfunction

   // --------------------------------------------------------------------------
   // Stimulus
   // --------------------------------------------------------------------------

   // pacing: mostly short gaps, a few long ones, and runs of back-to-back beats
   task automatic queue_job(input logic signed [31:0] lo, input logic signed [31:0] hi,
                            input logic [20:0] steps, input logic signed [31:0] width,
                            input logic [2:0] expo, input bit settle);
      integral_job_type j;
      j.lo     = lo;
      j.hi     = hi;
      j.steps  = steps;
      j.width  = width;
      j.expo   = expo;
      j.settle = settle;
      if (calm_left > 0) begin
         j.gap = 0;
         calm_left--;
      end else begin
         case ($urandom_range(15))
            0:             begin calm_left = $urandom_range(12, 4); j.gap = 0; end
            1:             j.gap = $urandom_range(300, 40);
            2, 3, 4:       j.gap = $urandom_range(12, 4);
            5, 6, 7, 8, 9: j.gap = $urandom_range(3, 1);
            default:       j.gap = 0;
         endcase
      end
      job_q.push_back(j);
   endtask

   // mostly within +/-4.0, sometimes any pattern or a rail
   function automatic logic signed [31:0] rand_point();
      case ($urandom_range(9))
         0:       return QMIN;
         1:       return QMAX;
         2, 3:    return $urandom();
         default: return 32'($urandom_range(32'h0800_0000)) - 32'sh0400_0000;
      endcase
   endfunction

   initial begin
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] w;
      logic        [20:0] n;

      // directed corners
      queue_job(0, 2 * ONE, 4, ONE / 2, 2, 0);            // x^2 on [0,2]
      queue_job(0, 2 * ONE, 4, ONE / 2, 0, 0);            // power zero acts as one
      queue_job(-ONE, ONE, 8, ONE / 4, 1, 0);
      queue_job(-ONE, ONE, 8, ONE / 4, 3, 0);
      queue_job(-ONE, ONE, 8, ONE / 4, 4, 0);
      queue_job(ONE / 2, 3 * ONE / 2, 4, ONE / 4, 5, 0);  // powers above the limit
      queue_job(ONE / 2, 3 * ONE / 2, 4, ONE / 4, 6, 0);
      queue_job(ONE / 2, 3 * ONE / 2, 4, ONE / 4, 7, 0);
      queue_job(ONE, 3 * ONE, 0, 2 * ONE, 2, 0);          // no trapezoids at all
      queue_job(ONE, 3 * ONE, 1, 2 * ONE, 2, 0);          // single trapezoid
      queue_job(QMIN, QMAX, 3, QMAX, 4, 0);               // rails everywhere
      queue_job(QMAX, QMIN, 2, QMIN, 3, 0);
      queue_job(QMAX, QMAX, 20, QMAX, 4, 0);              // final product saturates
      queue_job(QMIN, QMIN, 20, QMIN, 4, 0);              // powers saturate high
      queue_job(QMIN, QMIN, 100, QMIN, 3, 0);             // powers saturate low
      queue_job(ONE, ONE, 6, 0, 2, 0);                    // zero width
      queue_job(2 * ONE, -ONE, 5, -ONE / 2, 3, 1);        // bounds disagree, drain first
      queue_job(1, -1, 3, 1, 2, 0);                       // LSB values, rounding to zero
      queue_job(-3, 5, 2, -1, 1, 0);                      // LSB ends of opposite sign, negative width
      queue_job(0, ONE, 21'h1f_ffff, 16, 0, 0);           // step count clamps to the max

      // random requests
      for (int i = 0; i < 100; i++) begin
         case ($urandom_range(49))
            0, 1, 2, 3:   n = $urandom_range(2047, 200);
            4:            n = 0;
            5, 6, 7, 8,
            9, 10, 11:    n = $urandom_range(200, 17);
            default:      n = $urandom_range(16, 1);
         endcase
         a = rand_point();
         b = rand_point();
         // usually a width that spans [a, b], otherwise anything
         if ($urandom_range(3) != 0 && n != 0)
            w = 32'((longint'(b) - longint'(a)) / longint'(n));
         else
            w = rand_point();
         queue_job(a, b, n, w, 3'($urandom_range(7)), $urandom_range(19) == 0);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // drain: every beat driven and every result back
      do
         @(negedge clock);
      while (job_q.size() != 0 || start || in_flight > 0);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (area_q.size() != 0) begin
         $display("%0d predicted results never arrived", area_q.size());
         miss_cnt += area_q.size();
      end
      if (miss_cnt == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // stop a hung regression with a timeout
   initial begin
      #400_000_000;
      $display("timeout: %0d requests queued, %0d results pending",
               job_q.size(), area_q.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   // --------------------------------------------------------------------------
   // Driver: start/busy command beats
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : drive
      logic take;
      if (reset) begin
         start     <= 1'b0;
         in_flight  = 0;
         idle_cnt   = 0;
      end else begin
         take = start && !busy;
         if (take) begin
            area_q.push_back(trapezoid_area(cur_job));
            in_flight++;
         end
         // own count of outstanding results, so no race with the monitor
         if (rsp_valid)
            in_flight--;
         if (take || !start) begin
            if (job_q.size() != 0 && idle_cnt >= job_q[0].gap &&
                (!job_q[0].settle || in_flight <= 0)) begin
               cur_job = job_q.pop_front();
               req_lower_bound <= cur_job.lo;
               req_upper_bound <= cur_job.hi;
               req_step_count  <= cur_job.steps;
               req_step_width  <= cur_job.width;
               req_power       <= cur_job.expo;
               start           <= 1'b1;
               idle_cnt         = 0;
            end else begin
               start    <= 1'b0;
               idle_cnt++;
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // Monitor: one-cycle result strobe against the oldest prediction
   // --------------------------------------------------------------------------
   task automatic note_miss(input string what, input logic [63:0] want,
                            input logic [63:0] got);
      if (miss_cnt < REPORT_LIMIT)
         $display("mismatch %s: expected %h got %h", what, want, got);
      miss_cnt++;
   endtask

   always @(posedge clock) begin : check
      area_type want;
      if (!reset && rsp_valid) begin
         if (area_q.size() == 0) begin
            note_miss("unexpected result beat", '0, rsp_area);
         end else begin
            want = area_q.pop_front();
            if (rsp_area !== want.area)
               note_miss("area", want.area, rsp_area);
            if (rsp_overflowed !== want.overflowed)
               note_miss("overflowed", 64'(want.overflowed), 64'(rsp_overflowed));
         end
      end
   end

endmodule

@@ sim.f @@
sv/tpi_pkg.sv
sv/trapezoid_power_integrator.sv
sv/tpi_checker.sv
tb/sv/trapezoid_power_integrator_test.sv
